// ===== rtl/qvr_pkg.sv =====
// Package: widths, types and register codes for the quaternion vector rotator.
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int VEC_W     = 24;
    localparam int QUAT_W    = 16;
    localparam int QUAT_FRAC = QUAT_W - 2;
    localparam int GUARD     = 4;
    localparam int SHIFT1    = QUAT_FRAC - GUARD;
    localparam int SHIFT2    = QUAT_FRAC + GUARD;

    // first product q*(v,0): three terms per component, then round to guard scale
    localparam int PROD1_W = VEC_W + QUAT_W;
    localparam int SUM1_W  = PROD1_W + 1;
    localparam int T_W     = SUM1_W - SHIFT1;

    // second product t*conj(q): four terms per component
    localparam int PROD2_W = T_W + QUAT_W;
    localparam int SUM2_W  = PROD2_W + 2;
    localparam int R_W     = SUM2_W - SHIFT2;

    localparam int PIPE_LAT  = 5;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_X = 2'd0,
        REG_QUAT_Y = 2'd1,
        REG_QUAT_Z = 2'd2,
        REG_QUAT_W = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] w;
    } quat_t;

    typedef struct packed {
        logic                  valid;
        logic signed [T_W-1:0] x;
        logic signed [T_W-1:0] y;
        logic signed [T_W-1:0] z;
        logic signed [T_W-1:0] w;
    } tquat_t;

    typedef struct packed {
        logic                  valid;
        logic signed [R_W-1:0] x;
        logic signed [R_W-1:0] y;
        logic signed [R_W-1:0] z;
    } rvec_t;

endpackage

// ===== rtl/qvr_fwd.sv =====
// First Hamilton product t = q*(v,0): multiply stage, then sum and round stage.
`timescale 1ns / 1ps

module qvr_fwd (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vx,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vy,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vz,
    input  qvr_pkg::quat_t                      quat,
    output qvr_pkg::tquat_t                     t_out
);
    import qvr_pkg::*;

    localparam logic signed [SUM1_W-1:0] RND1 = SUM1_W'(1) << (SHIFT1 - 1);

    // products: w*v, cross terms, dot terms
    logic signed [PROD1_W-1:0] wvx_reg, wvy_reg, wvz_reg;
    logic signed [PROD1_W-1:0] yvz_reg, zvy_reg, zvx_reg, xvz_reg, xvy_reg, yvx_reg;
    logic signed [PROD1_W-1:0] xvx_reg, yvy_reg, zvz_reg;
    logic                      p_valid_reg;

    logic signed [SUM1_W-1:0]  sx, sy, sz, sw;
    logic signed [SUM1_W-1:0]  shx, shy, shz, shw;
    tquat_t                    t_reg;
    tquat_t                    t_next;

    function automatic logic signed [PROD1_W-1:0] mul1(
        input logic signed [QUAT_W-1:0] a,
        input logic signed [VEC_W-1:0]  b
    );
        mul1 = PROD1_W'(a) * PROD1_W'(b);
    endfunction

    function automatic logic signed [SUM1_W-1:0] ext1(input logic signed [PROD1_W-1:0] a);
        ext1 = SUM1_W'(a);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            t_reg       <= '0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            t_reg       <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wvx_reg <= mul1(quat.w, vx);
        wvy_reg <= mul1(quat.w, vy);
        wvz_reg <= mul1(quat.w, vz);
        yvz_reg <= mul1(quat.y, vz);
        zvy_reg <= mul1(quat.z, vy);
        zvx_reg <= mul1(quat.z, vx);
        xvz_reg <= mul1(quat.x, vz);
        xvy_reg <= mul1(quat.x, vy);
        yvx_reg <= mul1(quat.y, vx);
        xvx_reg <= mul1(quat.x, vx);
        yvy_reg <= mul1(quat.y, vy);
        zvz_reg <= mul1(quat.z, vz);
    end

    always_comb
    begin
        sx = ext1(wvx_reg) + ext1(yvz_reg) - ext1(zvy_reg) + RND1;
        sy = ext1(wvy_reg) + ext1(zvx_reg) - ext1(xvz_reg) + RND1;
        sz = ext1(wvz_reg) + ext1(xvy_reg) - ext1(yvx_reg) + RND1;
        // scalar part is minus the dot product
        sw = RND1 - ext1(xvx_reg) - ext1(yvy_reg) - ext1(zvz_reg);
        shx = sx >>> SHIFT1;
        shy = sy >>> SHIFT1;
        shz = sz >>> SHIFT1;
        shw = sw >>> SHIFT1;
        t_next.valid = p_valid_reg;
        t_next.x     = signed'(shx[T_W-1:0]);
        t_next.y     = signed'(shy[T_W-1:0]);
        t_next.z     = signed'(shz[T_W-1:0]);
        t_next.w     = signed'(shw[T_W-1:0]);
    end

    assign t_out = t_reg;

endmodule

// ===== rtl/qvr_conj.sv =====
// Second Hamilton product r = t*conj(q): multiply stage, then sum and round stage.
`timescale 1ns / 1ps

module qvr_conj (
    input  logic            clk,
    input  logic            rst_n,
    input  qvr_pkg::tquat_t t_in,
    input  qvr_pkg::quat_t  quat,
    output qvr_pkg::rvec_t  r_out
);
    import qvr_pkg::*;

    localparam logic signed [SUM2_W-1:0] RND2 = SUM2_W'(1) << (SHIFT2 - 1);

    logic signed [PROD2_W-1:0] wtx_reg, wty_reg, wtz_reg;
    logic signed [PROD2_W-1:0] twx_reg, twy_reg, twz_reg;
    logic signed [PROD2_W-1:0] tyz_reg, tzy_reg, tzx_reg, txz_reg, txy_reg, tyx_reg;
    logic                      p_valid_reg;

    logic signed [SUM2_W-1:0]  sx, sy, sz;
    logic signed [SUM2_W-1:0]  shx, shy, shz;
    rvec_t                     r_reg;
    rvec_t                     r_next;

    function automatic logic signed [PROD2_W-1:0] mul2(
        input logic signed [T_W-1:0]    a,
        input logic signed [QUAT_W-1:0] b
    );
        mul2 = PROD2_W'(a) * PROD2_W'(b);
    endfunction

    function automatic logic signed [SUM2_W-1:0] ext2(input logic signed [PROD2_W-1:0] a);
        ext2 = SUM2_W'(a);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            r_reg       <= '0;
        end
        else
        begin
            p_valid_reg <= t_in.valid;
            r_reg       <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wtx_reg <= mul2(t_in.x, quat.w);
        wty_reg <= mul2(t_in.y, quat.w);
        wtz_reg <= mul2(t_in.z, quat.w);
        twx_reg <= mul2(t_in.w, quat.x);
        twy_reg <= mul2(t_in.w, quat.y);
        twz_reg <= mul2(t_in.w, quat.z);
        tyz_reg <= mul2(t_in.y, quat.z);
        tzy_reg <= mul2(t_in.z, quat.y);
        tzx_reg <= mul2(t_in.z, quat.x);
        txz_reg <= mul2(t_in.x, quat.z);
        txy_reg <= mul2(t_in.x, quat.y);
        tyx_reg <= mul2(t_in.y, quat.x);
    end

    always_comb
    begin
        // conj(q) negates the vector part: subtract instead of negating
        sx = ext2(wtx_reg) + ext2(tzy_reg) - ext2(twx_reg) - ext2(tyz_reg) + RND2;
        sy = ext2(wty_reg) + ext2(txz_reg) - ext2(twy_reg) - ext2(tzx_reg) + RND2;
        sz = ext2(wtz_reg) + ext2(tyx_reg) - ext2(twz_reg) - ext2(txy_reg) + RND2;
        shx = sx >>> SHIFT2;
        shy = sy >>> SHIFT2;
        shz = sz >>> SHIFT2;
        r_next.valid = p_valid_reg;
        r_next.x     = signed'(shx[R_W-1:0]);
        r_next.y     = signed'(shy[R_W-1:0]);
        r_next.z     = signed'(shz[R_W-1:0]);
    end

    assign r_out = r_reg;

endmodule

// ===== rtl/qvr_sat.sv =====
// Output stage: clamp each component to the vector range and register with the strobe.
`timescale 1ns / 1ps

module qvr_sat (
    input  logic                             clk,
    input  logic                             rst_n,
    input  qvr_pkg::rvec_t                   r_in,
    output logic                             done,
    output logic signed [qvr_pkg::VEC_W-1:0] rot_x,
    output logic signed [qvr_pkg::VEC_W-1:0] rot_y,
    output logic signed [qvr_pkg::VEC_W-1:0] rot_z
);
    import qvr_pkg::*;

    localparam logic signed [R_W-1:0] SAT_HI = {{(R_W-VEC_W+1){1'b0}}, {(VEC_W-1){1'b1}}};
    localparam logic signed [R_W-1:0] SAT_LO = {{(R_W-VEC_W+1){1'b1}}, {(VEC_W-1){1'b0}}};

    logic                     done_reg;
    logic signed [VEC_W-1:0]  rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [VEC_W-1:0]  rot_x_next, rot_y_next, rot_z_next;

    function automatic logic signed [VEC_W-1:0] clamp(input logic signed [R_W-1:0] a);
        if (a > SAT_HI)
            clamp = signed'(SAT_HI[VEC_W-1:0]);
        else if (a < SAT_LO)
            clamp = signed'(SAT_LO[VEC_W-1:0]);
        else
            clamp = signed'(a[VEC_W-1:0]);
    endfunction

    always_comb
    begin
        rot_x_next = clamp(r_in.x);
        rot_y_next = clamp(r_in.y);
        rot_z_next = clamp(r_in.z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= r_in.valid;
    end

    always_ff @(posedge clk)
    begin
        rot_x_reg <= rot_x_next;
        rot_y_reg <= rot_y_next;
        rot_z_reg <= rot_z_next;
    end

    assign done  = done_reg;
    assign rot_x = rot_x_reg;
    assign rot_y = rot_y_reg;
    assign rot_z = rot_z_reg;

endmodule

// ===== rtl/quaternion_vector_rotate.sv =====
// Top level: configuration registers and the five-stage rotation pipeline.
//
//   channel   direction  handshake         payload
//   command   in         start, busy       vec_x, vec_y, vec_z
//   result    out        done (strobe)     rot_x, rot_y, rot_z
//   config    in         cfg_we            cfg_idx, cfg_data
//
// One vector enters per clock; busy stays low, so every start is taken.
// Each result shows on done after two stages per
// Hamilton product (multiply, then sum and round) and one saturating output stage.
// Reset clears the pipeline valid bits and loads the identity quaternion.
// Results cannot be held off; the pipeline never stalls.
`timescale 1ns / 1ps

module quaternion_vector_rotate (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vec_x,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vec_y,
    input  logic signed [qvr_pkg::VEC_W-1:0]    vec_z,
    output logic                                done,
    output logic signed [qvr_pkg::VEC_W-1:0]    rot_x,
    output logic signed [qvr_pkg::VEC_W-1:0]    rot_y,
    output logic signed [qvr_pkg::VEC_W-1:0]    rot_z,
    input  logic                                cfg_we,
    input  logic        [qvr_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic        [qvr_pkg::QUAT_W-1:0]   cfg_data
);
    import qvr_pkg::*;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1) << QUAT_FRAC;

    quat_t  quat_reg;
    tquat_t t_bus;
    rvec_t  r_bus;
    logic   in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
            quat_reg.w <= QUAT_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_idx))
                REG_QUAT_X: quat_reg.x <= signed'(cfg_data);
                REG_QUAT_Y: quat_reg.y <= signed'(cfg_data);
                REG_QUAT_Z: quat_reg.z <= signed'(cfg_data);
                REG_QUAT_W: quat_reg.w <= signed'(cfg_data);
                default:    quat_reg   <= quat_reg;
            endcase
        end
    end

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    qvr_fwd u_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .vx       (vec_x),
        .vy       (vec_y),
        .vz       (vec_z),
        .quat     (quat_reg),
        .t_out    (t_bus)
    );

    qvr_conj u_conj (
        .clk   (clk),
        .rst_n (rst_n),
        .t_in  (t_bus),
        .quat  (quat_reg),
        .r_out (r_bus)
    );

    qvr_sat u_sat (
        .clk   (clk),
        .rst_n (rst_n),
        .r_in  (r_bus),
        .done  (done),
        .rot_x (rot_x),
        .rot_y (rot_y),
        .rot_z (rot_z)
    );

endmodule

// ===== rtl/qvr_check.sv =====
// Port-level checker for the rotator, bound to the top level.
`timescale 1ns / 1ps

module qvr_check (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic signed [qvr_pkg::VEC_W-1:0] vec_x,
    input logic signed [qvr_pkg::VEC_W-1:0] vec_y,
    input logic signed [qvr_pkg::VEC_W-1:0] vec_z,
    input logic                             done,
    input logic signed [qvr_pkg::VEC_W-1:0] rot_x,
    input logic signed [qvr_pkg::VEC_W-1:0] rot_y,
    input logic signed [qvr_pkg::VEC_W-1:0] rot_z
);
    import qvr_pkg::*;

    // every accepted item yields a strobe after the pipeline latency
    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("accepted item produced no result");

    // no strobe without an item accepted at the matching earlier edge
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result strobe with no matching item");

    // a zero vector rotates to zero under any quaternion
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && vec_x == '0 && vec_y == '0 && vec_z == '0)
        |-> ##PIPE_LAT (rot_x == '0 && rot_y == '0 && rot_z == '0))
        else $error("zero vector gave nonzero result");

    // the pipeline takes an item every cycle
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind quaternion_vector_rotate qvr_check u_qvr_check (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .vec_x (vec_x),
    .vec_y (vec_y),
    .vec_z (vec_z),
    .done  (done),
    .rot_x (rot_x),
    .rot_y (rot_y),
    .rot_z (rot_z)
);

// ===== verif/tb_quaternion_vector_rotate.sv =====
// Testbench: directed and random vectors through the quaternion rotator, checked per field.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate;
    import qvr_pkg::*;

    typedef logic signed [VEC_W-1:0]  vec_word_t;
    typedef logic signed [QUAT_W-1:0] quat_word_t;

    typedef struct packed {
        vec_word_t x;
        vec_word_t y;
        vec_word_t z;
    } vec3_t;

    typedef struct packed {
        quat_t q;
        vec3_t v;
        logic  known;
        vec3_t want;
    } dir_row_t;

    localparam vec_word_t  VMAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam vec_word_t  VMIN = {1'b1, {(VEC_W-1){1'b0}}};
    localparam quat_word_t QONE = quat_word_t'(1 << QUAT_FRAC);
    localparam quat_word_t QMAX = {1'b0, {(QUAT_W-1){1'b1}}};
    localparam quat_word_t QMIN = {1'b1, {(QUAT_W-1){1'b0}}};
    localparam int LIMIT_NS    = 200000;
    localparam int DRAIN_LIMIT = 1000;
    localparam int MAX_SHOWN   = 10;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 50;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    vec_word_t            vec_x, vec_y, vec_z;
    logic                 done;
    vec_word_t            rot_x, rot_y, rot_z;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [QUAT_W-1:0]    cfg_data;

    quat_t quat_now;          // register copy, follows the writes seen at the port
    quat_t quat_set;          // last quaternion loaded by the driver
    vec3_t expected_rot[$];
    logic  pinned_valid;      // item in flight carries a hand-written expectation
    vec3_t pinned_rot;
    int    n_fail;

    quaternion_vector_rotate u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .vec_x    (vec_x),
        .vec_y    (vec_y),
        .vec_z    (vec_z),
        .done     (done),
        .rot_x    (rot_x),
        .rot_y    (rot_y),
        .rot_z    (rot_z),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic vec3_t v3(input vec_word_t x, input vec_word_t y, input vec_word_t z);
        vec3_t r;
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    // add half an LSB, then floor
    function automatic longint round_off(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic vec_word_t clamp_vec(input longint v);
        if (v > longint'(VMAX))
            return VMAX;
        if (v < longint'(VMIN))
            return VMIN;
        return vec_word_t'(v);
    endfunction

    // q * (v,0) * conj(q), first product rounded to guard scale
    function automatic vec3_t rotate_vec(input quat_t q, input vec3_t v);
        longint ux, uy, uz, w, vx, vy, vz;
        longint tx, ty, tz, tw, rx, ry, rz;
        vec3_t  r;
        ux = $signed(q.x);
        uy = $signed(q.y);
        uz = $signed(q.z);
        w  = $signed(q.w);
        vx = $signed(v.x);
        vy = $signed(v.y);
        vz = $signed(v.z);
        tx = round_off(w * vx + (uy * vz - uz * vy), SHIFT1);
        ty = round_off(w * vy + (uz * vx - ux * vz), SHIFT1);
        tz = round_off(w * vz + (ux * vy - uy * vx), SHIFT1);
        tw = round_off(-(ux * vx + uy * vy + uz * vz), SHIFT1);
        rx = -tw * ux + w * tx - ty * uz + tz * uy;
        ry = -tw * uy + w * ty - tz * ux + tx * uz;
        rz = -tw * uz + w * tz - tx * uy + ty * ux;
        r.x = clamp_vec(round_off(rx, SHIFT2));
        r.y = clamp_vec(round_off(ry, SHIFT2));
        r.z = clamp_vec(round_off(rz, SHIFT2));
        return r;
    endfunction

    always @(posedge clk)
    begin : result_check
        vec3_t got;
        vec3_t want;
        if (!rst_n) begin
            quat_now = '{x: '0, y: '0, z: '0, w: QONE};
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_idx))
                    REG_QUAT_X: quat_now.x = cfg_data;
                    REG_QUAT_Y: quat_now.y = cfg_data;
                    REG_QUAT_Z: quat_now.z = cfg_data;
                    REG_QUAT_W: quat_now.w = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                if (pinned_valid)
                    expected_rot.push_back(pinned_rot);
                else
                    expected_rot.push_back(rotate_vec(quat_now, v3(vec_x, vec_y, vec_z)));
            end
            if (done) begin
                got = v3(rot_x, rot_y, rot_z);
                if (expected_rot.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_SHOWN)
                        $display("result with nothing expected: %0d %0d %0d",
                                 got.x, got.y, got.z);
                end else begin
                    want = expected_rot.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                        n_fail++;
                        if (n_fail <= MAX_SHOWN)
                            $display("rotation mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want.x, want.y, want.z, got.x, got.y, got.z);
                    end
                end
            end
        end
    end

    function automatic vec_word_t rand_vec_word();
        case ($urandom_range(4))
            0: return VMAX;
            1: return VMIN;
            2: return vec_word_t'(int'($urandom_range(8191)) - 4096);
            default: return vec_word_t'($urandom);
        endcase
    endfunction

    function automatic quat_word_t rand_quat_word();
        case ($urandom_range(6))
            0: return QMIN;
            1: return QMAX;
            2: return '0;
            3: return $urandom_range(1) ? QONE : -QONE;
            4: return quat_word_t'(int'($urandom_range(16384)) - 8192);
            default: return quat_word_t'($urandom);
        endcase
    endfunction

    // present one item, hold it until taken
    task automatic send_vec(input vec3_t v, input logic known, input vec3_t want,
                            input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        pinned_valid = known;
        pinned_rot   = want;
        start <= 1'b1;
        vec_x <= v.x;
        vec_y <= v.y;
        vec_z <= v.z;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        pinned_valid = 1'b0;
    endtask

    // drop start and wait for every result in flight
    task automatic settle();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (expected_rot.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input quat_word_t data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic load_quat(input quat_t q);
        settle();
        write_reg(REG_QUAT_X, q.x);
        write_reg(REG_QUAT_Y, q.y);
        write_reg(REG_QUAT_Z, q.z);
        write_reg(REG_QUAT_W, q.w);
        cfg_we <= 1'b0;
        quat_set = q;
    endtask

    initial
    begin : stimulus
        dir_row_t rows[$];
        quat_t    q_id, q_zero, q_neg_w, q_z180, q_x90, q_all_min, q_mixed, q_tiny, q_odd;
        int       idle_pct;
        rst_n        = 1'b0;
        start        = 1'b0;
        vec_x        = '0;
        vec_y        = '0;
        vec_z        = '0;
        cfg_we       = 1'b0;
        cfg_idx      = REG_QUAT_X;
        cfg_data     = '0;
        pinned_valid = 1'b0;
        pinned_rot   = '0;
        n_fail       = 0;

        q_id      = '{x: '0, y: '0, z: '0, w: QONE};
        q_zero    = '{x: '0, y: '0, z: '0, w: '0};
        q_neg_w   = '{x: '0, y: '0, z: '0, w: QMIN};
        q_z180    = '{x: '0, y: '0, z: QONE, w: '0};
        q_x90     = '{x: 16'sd11585, y: '0, z: '0, w: 16'sd11585};
        q_all_min = '{x: QMIN, y: QMIN, z: QMIN, w: QMIN};
        q_mixed   = '{x: QMAX, y: QMIN, z: QMAX, w: QMIN};
        q_tiny    = '{x: 16'sd1, y: 16'sd1, z: 16'sd1, w: 16'sd1};
        q_odd     = '{x: 16'sd1000, y: -16'sd3, z: 16'sd7, w: 16'sd16000};
        quat_set  = q_id;

        // identity after reset passes vectors through untouched
        rows.push_back('{q_id, v3(0, 0, 0), 1'b1, v3(0, 0, 0)});
        rows.push_back('{q_id, v3(VMAX, VMAX, VMAX), 1'b1, v3(VMAX, VMAX, VMAX)});
        rows.push_back('{q_id, v3(VMIN, VMIN, VMIN), 1'b1, v3(VMIN, VMIN, VMIN)});
        rows.push_back('{q_id, v3(VMAX, VMIN, 1), 1'b1, v3(VMAX, VMIN, 1)});
        rows.push_back('{q_id, v3(-1, 1, -1), 1'b1, v3(-1, 1, -1)});
        rows.push_back('{q_zero, v3(VMAX, VMIN, 12345), 1'b1, v3(0, 0, 0)});
        // w of full negative scale: |q|^2 = 4, saturates at the rails
        rows.push_back('{q_neg_w, v3(VMAX, VMIN, 1), 1'b1, v3(VMAX, VMIN, 4)});
        rows.push_back('{q_neg_w, v3(1000, -1000, 0), 1'b1, v3(4000, -4000, 0)});
        // half turn about z negates x and y; negating the minimum saturates
        rows.push_back('{q_z180, v3(VMIN, VMAX, VMIN), 1'b1, v3(VMAX, -VMAX, VMIN)});
        rows.push_back('{q_z180, v3(5, -7, 9), 1'b1, v3(-5, 7, 9)});
        rows.push_back('{q_x90, v3(1, 2, 3), 1'b0, '0});
        rows.push_back('{q_x90, v3(VMAX, VMAX, VMAX), 1'b0, '0});
        rows.push_back('{q_all_min, v3(VMAX, VMIN, VMAX), 1'b0, '0});
        rows.push_back('{q_all_min, v3(1, 1, 1), 1'b0, '0});
        rows.push_back('{q_mixed, v3(VMIN, VMAX, 0), 1'b0, '0});
        rows.push_back('{q_mixed, v3(-2, 3, -4), 1'b0, '0});
        rows.push_back('{q_tiny, v3(513, -511, 1023), 1'b0, '0});
        rows.push_back('{q_odd, v3(123457, -654321, 8388000), 1'b0, '0});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i]) begin
            if (rows[i].q != quat_set)
                load_quat(rows[i].q);
            send_vec(rows[i].v, rows[i].known, rows[i].want, 33);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            idle_pct = (p < 3) ? 33 : (p < 6) ? 69 : 0;
            load_quat('{x: rand_quat_word(), y: rand_quat_word(),
                        z: rand_quat_word(), w: rand_quat_word()});
            repeat (PHASE_ITEMS)
                send_vec(v3(rand_vec_word(), rand_vec_word(), rand_vec_word()),
                         1'b0, '0, idle_pct);
        end

        settle();
        repeat (PIPE_LAT + 3) @(negedge clk);
        if (expected_rot.size() != 0) begin
            $display("%0d expected results never arrived", expected_rot.size());
            n_fail += expected_rot.size();
        end
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
